/* src/scb_pkg.sv */
// Package for the segmented chain hash bucket store.
// Holds operation and status codes and the request/response transaction types.
// No dependencies.
package scb_pkg;

  localparam int unsigned PRB_W = 12;
  localparam logic [PRB_W-1:0] PRB_MAX = {PRB_W{1'b1}};

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_NO_SEGMENT = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  bucket_number;
    logic [63:0] search_key;
    logic [63:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      found_value;
    logic [PRB_W-1:0] probe_count;
  } rsp_t;

endpackage

/* src/scb_req_if.sv */
// Request channel of the segmented chain hash bucket store.
// Depends on scb_pkg for the request transaction type.
interface scb_req_if import scb_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/scb_rsp_if.sv */
// Response channel of the segmented chain hash bucket store.
// Depends on scb_pkg for the response transaction type.
interface scb_rsp_if import scb_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/scb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module scb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/segmented_chain_hash_buckets_unit.sv */
// Top level of the segmented chain hash bucket store.
// Depends on scb_pkg, scb_req_if, scb_rsp_if and scb_ram.

// Hash-table bucket store: every bucket heads a chain of segments of
// SEGMENT_SLOTS entries taken from a pool of POOL_SEGMENTS segments. One
// transaction is worked at a time. A request is accepted in S_IDLE and the
// bucket head is read in S_HEAD; each segment visited then passes through S_RD
// (segment memory read) and S_EV (a parallel compare of all slots of that
// segment), and S_DONE hands the result to the output register, waiting while
// that register is still full; an insert that links a new tail segment also
// passes through S_LINK and S_NEW. Bucket head valid bits reset at once and
// the free segment stack is tracked by a low-water mark, so there is no
// clearing pass after reset.
module segmented_chain_hash_buckets_unit import scb_pkg::*; #(
  parameter int unsigned BUCKET_COUNT  = 256,
  parameter int unsigned SEGMENT_SLOTS = 4,
  parameter int unsigned POOL_SEGMENTS = 512,
  parameter int unsigned KEY_BITS      = 64,
  parameter int unsigned VALUE_BITS    = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scb_req_if.sink    req_i,
  scb_rsp_if.source  rsp_o
);

  localparam int unsigned BKT_W  = $clog2(BUCKET_COUNT);
  localparam int unsigned SEG_W  = $clog2(POOL_SEGMENTS);
  localparam int unsigned CNT_W  = $clog2(POOL_SEGMENTS + 1);
  localparam int unsigned FILL_W = $clog2(SEGMENT_SLOTS + 1);
  localparam int unsigned SLOT_W = SEGMENT_SLOTS > 1 ? $clog2(SEGMENT_SLOTS) : 1;
  localparam int unsigned EW     = KEY_BITS + VALUE_BITS;
  localparam int unsigned ROW_W  = SEGMENT_SLOTS * EW;
  localparam int unsigned SW     = 1 + SEG_W + FILL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_HEAD, S_RD, S_EV, S_LINK, S_NEW, S_DONE
  } state_e;

  state_e                  state_q;
  logic [1:0]              op_q;
  logic [BKT_W-1:0]        bkt_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   val_q;
  logic [SEG_W-1:0]        seg_q;
  logic [SEG_W-1:0]        prev_q;
  logic [FILL_W-1:0]       prev_fill_q;
  logic                    have_prev_q;
  logic [FILL_W-1:0]       cur_fill_q;
  logic [SEG_W-1:0]        fresh_q;
  logic [PRB_W-1:0]        probe_q;
  logic [1:0]              status_q;
  logic [VALUE_BITS-1:0]   found_q;
  logic [CNT_W-1:0]        free_cnt_q;
  logic [CNT_W-1:0]        lo_q;
  logic [BUCKET_COUNT-1:0] head_vld_q;
  logic                    out_vld_q;
  rsp_t                    out_q;

  // Memory ports.
  logic                    head_we, head_re;
  logic [BKT_W-1:0]        head_waddr, head_raddr;
  logic [SEG_W-1:0]        head_wdata, head_rdata;
  logic                    seg_we, seg_re;
  logic [SEG_W-1:0]        seg_waddr;
  logic [SW-1:0]           seg_wdata, seg_rdata;
  logic                    ent_we, ent_re;
  logic [SEG_W-1:0]        ent_waddr;
  logic [ROW_W-1:0]        ent_wdata, ent_rdata;
  logic                    stk_we, stk_re;
  logic [SEG_W-1:0]        stk_waddr, stk_raddr;
  logic [SEG_W-1:0]        stk_wdata, stk_rdata;

  scb_ram #(.WIDTH(SEG_W), .DEPTH(BUCKET_COUNT)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  scb_ram #(.WIDTH(SW), .DEPTH(POOL_SEGMENTS)) u_seg_ram (
    .clk_i, .we_i(seg_we), .waddr_i(seg_waddr), .wdata_i(seg_wdata),
    .re_i(seg_re), .raddr_i(seg_q), .rdata_o(seg_rdata)
  );
  scb_ram #(.WIDTH(ROW_W), .DEPTH(POOL_SEGMENTS)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .re_i(ent_re), .raddr_i(seg_q), .rdata_o(ent_rdata)
  );
  scb_ram #(.WIDTH(SEG_W), .DEPTH(POOL_SEGMENTS)) u_stk_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // Bucket number reduced modulo the bucket count by conditional subtraction.
  logic [31:0]      bkt_rem;
  logic [BKT_W-1:0] bkt_idx;
  always_comb begin
    bkt_rem = 32'(req_i.data.bucket_number);
    for (int k = 7; k >= 0; k--) begin
      if (bkt_rem >= (32'(BUCKET_COUNT) << k)) begin
        bkt_rem = bkt_rem - (32'(BUCKET_COUNT) << k);
      end
    end
    bkt_idx = bkt_rem[BKT_W-1:0];
  end

  logic req_acc;
  assign req_acc     = req_i.valid && (state_q == S_IDLE);
  assign req_i.ready = (state_q == S_IDLE);

  // Top of the free stack; entries below the low-water mark were never written.
  logic [CNT_W-1:0] top_idx;
  logic [SEG_W-1:0] fresh_c;
  logic             pool_empty;
  assign top_idx    = free_cnt_q - CNT_W'(1);
  assign pool_empty = (free_cnt_q == '0);
  assign fresh_c    = (top_idx < lo_q) ?
                      (SEG_W'(POOL_SEGMENTS - 1) - top_idx[SEG_W-1:0]) : stk_rdata;

  // Fields of the segment word read back.
  logic              cur_lv;
  logic [SEG_W-1:0]  cur_link;
  logic [FILL_W-1:0] cur_fill;
  logic [FILL_W-1:0] cur_fc;
  assign {cur_lv, cur_link, cur_fill} = seg_rdata;
  assign cur_fc = (cur_fill > FILL_W'(SEGMENT_SLOTS)) ? FILL_W'(SEGMENT_SLOTS) : cur_fill;

  // Parallel compare of all slots, first hit wins.
  logic                  hit;
  logic [SLOT_W-1:0]     hit_slot;
  logic [KEY_BITS-1:0]   slot_key [SEGMENT_SLOTS];
  logic [VALUE_BITS-1:0] slot_val [SEGMENT_SLOTS];
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < SEGMENT_SLOTS; i++) begin
      slot_key[i] = ent_rdata[i*EW +: KEY_BITS];
      slot_val[i] = ent_rdata[i*EW + KEY_BITS +: VALUE_BITS];
    end
    for (int i = SEGMENT_SLOTS - 1; i >= 0; i--) begin
      if ((FILL_W'(i) < cur_fc) && (slot_key[i] == key_q)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  logic [SLOT_W-1:0] last_slot;
  assign last_slot = SLOT_W'(cur_fc - FILL_W'(1));

  // Saturating probe count update.
  logic [FILL_W-1:0] probe_amt;
  logic [PRB_W:0]    probe_sum;
  logic [PRB_W-1:0]  probe_nxt;
  always_comb begin
    probe_amt = cur_fill;
    if (op_q != OP_INSERT) begin
      probe_amt = hit ? FILL_W'(hit_slot) : cur_fc;
    end
    probe_sum = {1'b0, probe_q} + (PRB_W+1)'(probe_amt);
    probe_nxt = (probe_sum > (PRB_W+1)'(PRB_MAX)) ? PRB_MAX : probe_sum[PRB_W-1:0];
  end

  // Memory control for each state.
  always_comb begin
    head_we    = 1'b0;
    head_re    = 1'b0;
    head_waddr = bkt_q;
    head_raddr = bkt_idx;
    head_wdata = fresh_c;
    seg_we     = 1'b0;
    seg_re     = 1'b0;
    seg_waddr  = seg_q;
    seg_wdata  = seg_rdata;
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    ent_waddr  = seg_q;
    ent_wdata  = ent_rdata;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_waddr  = free_cnt_q[SEG_W-1:0];
    stk_raddr  = top_idx[SEG_W-1:0];
    stk_wdata  = seg_q;
    unique case (state_q)
      S_IDLE: begin
        head_re = req_acc;
        stk_re  = req_acc;
      end
      S_HEAD: begin
        head_we = (op_q == OP_INSERT) && !head_vld_q[bkt_q] && !pool_empty;
      end
      S_RD: begin
        seg_re = 1'b1;
        ent_re = 1'b1;
      end
      S_EV: begin
        if (op_q == OP_INSERT) begin
          if (cur_fill < FILL_W'(SEGMENT_SLOTS)) begin
            ent_we = 1'b1;
            ent_wdata[SLOT_W'(cur_fill)*EW +: EW] = {val_q, key_q};
            seg_we = 1'b1;
            seg_wdata = {cur_lv, cur_link, cur_fill + FILL_W'(1)};
          end
        end else if (op_q == OP_REMOVE && hit) begin
          if (cur_fc > FILL_W'(1)) begin
            ent_we = 1'b1;
            ent_wdata[hit_slot*EW +: EW] = ent_rdata[last_slot*EW +: EW];
            seg_we = 1'b1;
            seg_wdata = {cur_lv, cur_link, cur_fc - FILL_W'(1)};
          end else begin
            if (have_prev_q) begin
              seg_we    = 1'b1;
              seg_waddr = prev_q;
              seg_wdata = {cur_lv, cur_link, prev_fill_q};
            end else begin
              head_we    = 1'b1;
              head_wdata = cur_link;
            end
            stk_we = (free_cnt_q < CNT_W'(POOL_SEGMENTS));
          end
        end
      end
      S_LINK: begin
        seg_we    = 1'b1;
        seg_wdata = {1'b1, fresh_q, cur_fill_q};
      end
      S_NEW: begin
        seg_we    = 1'b1;
        seg_waddr = fresh_q;
        seg_wdata = {1'b0, SEG_W'(0), FILL_W'(1)};
        ent_we    = 1'b1;
        ent_waddr = fresh_q;
        ent_wdata[0 +: EW] = {val_q, key_q};
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, pool bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_cnt_q <= CNT_W'(POOL_SEGMENTS);
      lo_q       <= CNT_W'(POOL_SEGMENTS);
      head_vld_q <= '0;
      out_vld_q  <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      // A response taken while no new one is loaded empties the output register.
      if (rsp_o.valid && rsp_o.ready && (state_q != S_DONE)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            op_q        <= req_i.data.op;
            bkt_q       <= bkt_idx;
            key_q       <= req_i.data.search_key[KEY_BITS-1:0];
            val_q       <= req_i.data.new_value[VALUE_BITS-1:0];
            probe_q     <= PRB_W'(1);
            found_q     <= '0;
            have_prev_q <= 1'b0;
            state_q     <= S_HEAD;
          end
        end
        S_HEAD: begin
          fresh_q <= fresh_c;
          seg_q   <= head_rdata;
          if (op_q == OP_INSERT) begin
            if (head_vld_q[bkt_q]) begin
              state_q <= S_RD;
            end else if (pool_empty) begin
              status_q <= ST_NO_SEGMENT;
              state_q  <= S_DONE;
            end else begin
              head_vld_q[bkt_q] <= 1'b1;
              free_cnt_q <= top_idx;
              if (top_idx < lo_q) lo_q <= top_idx;
              status_q <= ST_OK;
              state_q  <= S_NEW;
            end
          end else if ((op_q == OP_LOOKUP || op_q == OP_REMOVE) && head_vld_q[bkt_q]) begin
            state_q <= S_RD;
          end else begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_DONE;
          end
        end
        S_RD: begin
          state_q <= S_EV;
        end
        S_EV: begin
          probe_q <= probe_nxt;
          if (op_q == OP_INSERT) begin
            cur_fill_q <= cur_fill;
            if (cur_fill < FILL_W'(SEGMENT_SLOTS)) begin
              status_q <= ST_OK;
              state_q  <= S_DONE;
            end else if (cur_lv) begin
              seg_q   <= cur_link;
              state_q <= S_RD;
            end else if (pool_empty) begin
              status_q <= ST_NO_SEGMENT;
              state_q  <= S_DONE;
            end else begin
              free_cnt_q <= top_idx;
              if (top_idx < lo_q) lo_q <= top_idx;
              status_q <= ST_OK;
              state_q  <= S_LINK;
            end
          end else if (hit) begin
            status_q <= ST_OK;
            state_q  <= S_DONE;
            if (op_q == OP_LOOKUP) begin
              found_q <= slot_val[hit_slot];
            end else if (cur_fc <= FILL_W'(1)) begin
              if (!have_prev_q) head_vld_q[bkt_q] <= cur_lv;
              if (free_cnt_q < CNT_W'(POOL_SEGMENTS)) free_cnt_q <= free_cnt_q + CNT_W'(1);
            end
          end else begin
            prev_q      <= seg_q;
            prev_fill_q <= cur_fill;
            have_prev_q <= 1'b1;
            seg_q       <= cur_link;
            if (cur_lv) begin
              state_q <= S_RD;
            end else begin
              status_q <= ST_NOT_FOUND;
              state_q  <= S_DONE;
            end
          end
        end
        S_LINK: begin
          state_q <= S_NEW;
        end
        S_NEW: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q         <= 1'b1;
            out_q.status      <= status_q;
            out_q.found_value <= 64'(found_q);
            out_q.probe_count <= probe_q;
            state_q           <= S_IDLE;
          end else begin
            out_vld_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  // Pool count stays within the pool and never falls below the low-water mark.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CNT_W'(POOL_SEGMENTS)) else $error("free count above pool size");
  a_lo_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= free_cnt_q) else $error("free count below low-water mark");
  // A returned value only comes with a successful status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.found_value != '0) |-> rsp_o.data.status == ST_OK)
    else $error("value returned with a failing status");
  // Linking a tail is always followed by initializing the new segment.
  a_link_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LINK |=> state_q == S_NEW) else $error("tail link without new segment");

endmodule
